>>> sv/crs_pkg.sv
`default_nettype none
package crs_pkg;

	localparam int DEFAULT_STACK_DEPTH = 16;

	// field widths of the stream items
	localparam int POS_W   = 14;
	localparam int SIZE_W  = 13;
	localparam int CLIPY_W = 15;
	localparam int CLIPS_W = 14;
	localparam int SCR_W   = 13;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 3;

	// internal width for edge arithmetic
	localparam int ACC_W = 18;
	// width of a pushed size or bottom edge before intersection
	localparam int PEND_W = 16;

	localparam logic [SCR_W-1:0] RESET_SCREEN_W = SCR_W'(1920);
	localparam logic [SCR_W-1:0] RESET_SCREEN_H = SCR_W'(1080);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 2'd1;

	// operation codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL  = 2'd2;

	// one stored rectangle, bottom-left origin
	typedef struct packed {
		logic signed [POS_W-1:0]   x;
		logic signed [CLIPY_W-1:0] y;
		logic [CLIPS_W-1:0]        w;
		logic [CLIPS_W-1:0]        h;
	} rect_t;

	// pushed rectangle after defaults and y flip, before intersection
	typedef struct packed {
		logic signed [POS_W-1:0]  x;
		logic signed [PEND_W-1:0] y;
		logic signed [PEND_W-1:0] w;
		logic signed [PEND_W-1:0] h;
	} pend_t;

endpackage
`default_nettype wire

>>> sv/crs_cell.sv
`default_nettype none
module crs_cell (
	input  wire                 clk,
	input  wire                 push,
	input  wire                 pop,
	input  crs_pkg::rect_t      from_above,
	input  crs_pkg::rect_t      from_below,
	output crs_pkg::rect_t      rect
);
	import crs_pkg::*;

	rect_t rect_q;

	// shift down on push, up on pop, hold otherwise
	always_ff @(posedge clk) begin
		if (push) begin
			rect_q <= from_above;
		end else if (pop) begin
			rect_q <= from_below;
		end
	end

	assign rect = rect_q;

endmodule
`default_nettype wire

>>> sv/crs_isect.sv
`default_nettype none
module crs_isect (
	input  crs_pkg::pend_t b,
	input  crs_pkg::rect_t t,
	input  wire            clip,
	output crs_pkg::rect_t r
);
	import crs_pkg::*;

	logic signed [ACC_W-1:0] bx, by, bw, bh;
	logic signed [ACC_W-1:0] tx, ty, tw, th;
	logic signed [ACC_W-1:0] nx, ny, nw, nh;
	logic signed [ACC_W-1:0] t_right, t_top, b_right, b_top;

	always_comb begin
		bx = ACC_W'(b.x);
		by = ACC_W'(b.y);
		bw = ACC_W'(b.w);
		bh = ACC_W'(b.h);
		tx = ACC_W'(t.x);
		ty = ACC_W'(t.y);
		tw = {{(ACC_W-CLIPS_W){1'b0}}, t.w};
		th = {{(ACC_W-CLIPS_W){1'b0}}, t.h};

		// raise left and bottom edges to the top rectangle's
		nx = (clip && tx > bx) ? tx : bx;
		ny = (clip && ty > by) ? ty : by;

		// lower right and top edges to the top rectangle's
		t_right = tx + tw;
		t_top   = ty + th;
		b_right = nx + bw;
		b_top   = ny + bh;
		nw = (clip && t_right < b_right) ? t_right - nx : bw;
		nh = (clip && t_top < b_top) ? t_top - ny : bh;

		// clamp negative sizes
		if (nw < 0) begin
			nw = '0;
		end
		if (nh < 0) begin
			nh = '0;
		end

		r.x = nx[POS_W-1:0];
		r.y = ny[CLIPY_W-1:0];
		r.w = nw[CLIPS_W-1:0];
		r.h = nh[CLIPS_W-1:0];
	end

endmodule
`default_nettype wire

>>> sv/clip_rect_stack_unit.sv
// An accepted item is held in the stage 1 register and then committed into
// the output register; a new item is not accepted until the last one commits.
// The push edge arithmetic is split over an input stage and a commit stage.
// The stack is a chain of rectangle cells that shifts on every push into a
// non-full stack and every pop from a non-empty one. Reset clears the fill
// count, the valid flags and the screen size registers (1920 by 1080); the cell contents stay unknown until pushed.
`default_nettype none
module clip_rect_stack_unit #(
	parameter int STACK_DEPTH = crs_pkg::DEFAULT_STACK_DEPTH
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration writes
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [crs_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [crs_pkg::SCR_W-1:0]            cfg_data,
	// input stream
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_x[13:0], pos_y[27:14], rect_width[40:28], rect_height[53:41], zero pad
	input  wire [crs_pkg::IN_DATA_W-1:0]        s_axis_tdata,
	// func[0]
	input  wire                                 s_axis_tuser,
	// output stream
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// clip_x[13:0], clip_y[28:14], clip_w[42:29], clip_h[56:43], zero pad
	output logic [crs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// scissor_enable[0], status[2:1]
	output logic [crs_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
	import crs_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [SCR_W-1:0] screen_w_q, screen_h_q;
	logic [CNT_W-1:0] count_q;

	logic   v_s1;
	logic   pop_s1;
	pend_t  b_s1;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [OUT_USER_W-1:0] m_user_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= RESET_SCREEN_W;
			screen_h_q <= RESET_SCREEN_H;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SCREEN_W) begin
				screen_w_q <= cfg_data;
			end else if (cfg_index == REG_SCREEN_H) begin
				screen_h_q <= cfg_data;
			end
		end
	end

	// stage 1: defaults for zero sizes and y flip
	logic signed [ACC_W-1:0] in_x, in_y, scr_w, scr_h, def_w, def_h, in_w, in_h, in_bot;
	logic in_acc;

	assign s_axis_tready = !v_s1;
	assign in_acc = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_x  = ACC_W'($signed(s_axis_tdata[POS_W-1:0]));
		in_y  = ACC_W'($signed(s_axis_tdata[2*POS_W-1:POS_W]));
		scr_w = {{(ACC_W-SCR_W){1'b0}}, screen_w_q};
		scr_h = {{(ACC_W-SCR_W){1'b0}}, screen_h_q};
		def_w = scr_w - in_x;
		def_h = scr_h - in_y;
		in_w  = (s_axis_tdata[2*POS_W+SIZE_W-1:2*POS_W] == '0) ? def_w :
			{{(ACC_W-SIZE_W){1'b0}}, s_axis_tdata[2*POS_W+SIZE_W-1:2*POS_W]};
		in_h  = (s_axis_tdata[2*POS_W+2*SIZE_W-1:2*POS_W+SIZE_W] == '0) ? def_h :
			{{(ACC_W-SIZE_W){1'b0}}, s_axis_tdata[2*POS_W+2*SIZE_W-1:2*POS_W+SIZE_W]};
		in_bot = scr_h - in_y - in_h;
	end

	// stack cells
	rect_t cell_rect [STACK_DEPTH];
	rect_t push_rect;
	logic  do_push, do_pop, commit;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		rect_t above, below;
		if (i == 0) begin : g_head
			assign above = push_rect;
		end else begin : g_mid
			assign above = cell_rect[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign below = cell_rect[i];
		end else begin : g_body
			assign below = cell_rect[i+1];
		end
		crs_cell u_cell (
			.clk        (clk),
			.push       (do_push),
			.pop        (do_pop),
			.from_above (above),
			.from_below (below),
			.rect       (cell_rect[i])
		);
	end

	// stage 2: intersect with the top and commit to the stack
	crs_isect u_isect (
		.b    (b_s1),
		.t    (cell_rect[0]),
		.clip (count_q != '0),
		.r    (push_rect)
	);

	logic       res_en;
	rect_t      res_rect;
	logic [1:0] res_status;

	assign commit = v_s1 && (!m_valid_q || m_axis_tready);

	always_comb begin
		res_en     = 1'b0;
		res_rect   = cell_rect[0];
		res_status = ST_OK;
		do_push    = 1'b0;
		do_pop     = 1'b0;
		if (pop_s1 == FUNC_PUSH) begin
			res_en = 1'b1;
			if (count_q == CNT_FULL) begin
				res_status = ST_PUSH_FULL;
			end else begin
				res_rect = push_rect;
				do_push  = commit;
			end
		end else begin
			priority if (count_q == '0) begin
				res_status = ST_POP_EMPTY;
			end else if (count_q == CNT_ONE) begin
				do_pop = commit;
			end else begin
				res_en   = 1'b1;
				res_rect = cell_rect[1];
				do_pop   = commit;
			end
		end
		if (!res_en) begin
			res_rect = '0;
		end
	end

	// control: stage valid, fill count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (commit) begin
				v_s1 <= 1'b0;
			end
			if (do_push) begin
				count_q <= count_q + CNT_ONE;
			end else if (do_pop) begin
				count_q <= count_q - CNT_ONE;
			end
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload: stage 1 and output registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pop_s1 <= s_axis_tuser;
			b_s1.x <= in_x[POS_W-1:0];
			b_s1.y <= in_bot[PEND_W-1:0];
			b_s1.w <= in_w[PEND_W-1:0];
			b_s1.h <= in_h[PEND_W-1:0];
		end
		if (commit) begin
			m_data_q <= {{(OUT_DATA_W-POS_W-CLIPY_W-2*CLIPS_W){1'b0}},
				res_rect.h, res_rect.w, res_rect.y, res_rect.x};
			m_user_q <= {res_status, res_en};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule
`default_nettype wire
